### design/xpf_pkg.sv
package xpf_pkg;

    // Fixed field widths.
    localparam int WORD_W   = 32;
    localparam int IDX_W    = 6;
    localparam int FRAMES_W = 4;

    // Default sizes of a frame and of a parity group.
    localparam int PAYLOAD_WORDS_DEF = 40;
    localparam int GROUP_FRAMES_DEF  = 2;

    // Stream widths: tdata is padded up to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Packet kinds.
    localparam logic PKT_DATA   = 1'b0;
    localparam logic PKT_PARITY = 1'b1;

    // One output beat.
    typedef struct packed {
        logic              ptype;
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  index;
        logic              last;
        logic              err;
    } beat_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RMW  = 5'b00010,
        ST_PUT  = 5'b00100,
        ST_PRD  = 5'b01000,
        ST_PPUT = 5'b10000
    } state_t;

endpackage

### design/xpf_ram.sv
module xpf_ram
    import xpf_pkg::*;
#(
    parameter int DEPTH = PAYLOAD_WORDS_DEF,
    parameter int AW    = 6
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/xor_parity_fec_encoder.sv
// XOR parity FEC encoder.
// Input stream: one frame word per beat. s_tdata carries the word, s_tuser marks
// the sequence word that opens a frame; a frame has PAYLOAD_WORDS payload words.
// Output stream: every accepted frame word comes out as a data packet beat. After the
// last payload word of every GROUP_FRAMES-th complete frame a parity packet
// follows: the group's first sequence word, then the XOR of the payload words.
// An early frame start restarts the group and sets the error flag on that beat.
// Payload words with no frame in progress are dropped.
// Sequencing: a sequence word goes straight to the output register; a payload
// word first reads its parity entry, then writes the updated entry back and
// hands on its beat. A parity packet sends its sequence beat, then reads each
// parity word from the memory and registers it at the output. s_tready is low meanwhile.
// Reset clears all control state; the parity memory needs no clearing, since
// the first frame of a group writes it instead of accumulating.
// When the receiver stalls, the output register holds its beat and the block
// stops at the next beat it must deliver; no input is accepted until then.
module xor_parity_fec_encoder
    import xpf_pkg::*;
#(
    parameter int PAYLOAD_WORDS = PAYLOAD_WORDS_DEF,
    parameter int GROUP_FRAMES  = GROUP_FRAMES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] word
    input  logic [0:0]           s_tuser,   // [0] frame_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] out_word, [37:32] word_index, zeros
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] packet_type, [1] frame_error
    output logic                 m_tlast    // packet_last
);

    localparam int AW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
    localparam logic [IDX_W-1:0]    LAST_POS  = IDX_W'(PAYLOAD_WORDS);
    localparam logic [FRAMES_W-1:0] GROUP_CNT = FRAMES_W'(GROUP_FRAMES);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [FRAMES_W-1:0]  frames_reg, frames_next;
    logic [WORD_W-1:0]    seq_reg, seq_next;
    logic                 first_reg, first_next;
    logic                 par_go_reg, par_go_next;
    logic [IDX_W-1:0]     par_idx_reg, par_idx_next;
    logic                 out_valid_reg, out_valid_next;
    beat_t                out_reg, out_next;
    beat_t                pend_reg, pend_next;
    logic [WORD_W-1:0]    word_reg, word_next;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_W-1:0]    ram_wdata, ram_rdata;

    logic                 in_fire, slot_free, do_put, start_err;
    logic [IDX_W-1:0]     pos_m1, idx_m1, par_idx_p1;
    logic [FRAMES_W-1:0]  frames_inc, frames_eff;

    xpf_ram #(
        .DEPTH (PAYLOAD_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    assign pos_m1     = pos_reg - IDX_W'(1);
    assign idx_m1     = pend_reg.index - IDX_W'(1);
    assign par_idx_p1 = par_idx_reg + IDX_W'(1);
    assign frames_inc = frames_reg + FRAMES_W'(1);
    assign start_err  = (pos_reg != '0);
    assign frames_eff = start_err ? '0 : frames_reg;

    // Memory addresses follow the payload position or the parity read index.
    assign ram_raddr = (state_reg == ST_PRD) ? par_idx_reg[AW-1:0] : pos_m1[AW-1:0];
    assign ram_waddr = idx_m1[AW-1:0];
    assign ram_wdata = (first_reg ? '0 : ram_rdata) ^ word_reg;

    // Sequencer for accept, read-modify-write and parity readout.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        frames_next    = frames_reg;
        seq_next       = seq_reg;
        first_next     = first_reg;
        par_go_next    = par_go_reg;
        par_idx_next   = par_idx_reg;
        pend_next      = pend_reg;
        word_next      = word_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        do_put         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && s_tuser[0])
                begin
                    // Sequence word: restart the group if a frame was cut short.
                    if (frames_eff == '0)
                    begin
                        seq_next = s_tdata;
                    end
                    frames_next     = frames_eff;
                    pos_next        = IDX_W'(1);
                    par_go_next     = 1'b0;
                    pend_next.ptype = PKT_DATA;
                    pend_next.word  = s_tdata;
                    pend_next.index = '0;
                    pend_next.last  = 1'b0;
                    pend_next.err   = start_err;
                    if (slot_free)
                    begin
                        out_next       = pend_next;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_PUT;
                    end
                end
                else if (in_fire && (pos_reg != '0) && (pos_reg <= LAST_POS))
                begin
                    // Payload word: read its parity entry.
                    ram_re          = 1'b1;
                    word_next       = s_tdata;
                    first_next      = (frames_reg == '0);
                    pend_next.ptype = PKT_DATA;
                    pend_next.word  = s_tdata;
                    pend_next.index = pos_reg;
                    pend_next.last  = (pos_reg == LAST_POS);
                    pend_next.err   = 1'b0;
                    if (pos_reg == LAST_POS)
                    begin
                        pos_next = '0;
                        if (frames_inc == GROUP_CNT)
                        begin
                            frames_next = '0;
                            par_go_next = 1'b1;
                        end
                        else
                        begin
                            frames_next = frames_inc;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + IDX_W'(1);
                    end
                    state_next = ST_RMW;
                end
            end
            ST_RMW:
            begin
                ram_we = 1'b1;
                if (slot_free)
                begin
                    do_put = 1'b1;
                end
                else
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (slot_free)
                begin
                    do_put = 1'b1;
                end
            end
            ST_PRD:
            begin
                ram_re     = 1'b1;
                state_next = ST_PPUT;
            end
            ST_PPUT:
            begin
                if (slot_free)
                begin
                    out_next.ptype = PKT_PARITY;
                    out_next.word  = ram_rdata;
                    out_next.index = par_idx_p1;
                    out_next.last  = (par_idx_p1 == LAST_POS);
                    out_next.err   = 1'b0;
                    out_valid_next = 1'b1;
                    par_idx_next   = par_idx_p1;
                    state_next     = (par_idx_p1 == LAST_POS) ? ST_IDLE : ST_PRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hand the pending beat to the output and pick what follows it.
        if (do_put)
        begin
            out_next       = pend_reg;
            out_valid_next = 1'b1;
            if (par_go_reg)
            begin
                pend_next.ptype = PKT_PARITY;
                pend_next.word  = seq_reg;
                pend_next.index = '0;
                pend_next.last  = 1'b0;
                pend_next.err   = 1'b0;
                par_go_next     = 1'b0;
                state_next      = ST_PUT;
            end
            else if (pend_reg.ptype == PKT_PARITY)
            begin
                par_idx_next = '0;
                state_next   = ST_PRD;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            frames_reg    <= '0;
            seq_reg       <= '0;
            first_reg     <= 1'b0;
            par_go_reg    <= 1'b0;
            par_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            frames_reg    <= frames_next;
            seq_reg       <= seq_next;
            first_reg     <= first_next;
            par_go_reg    <= par_go_next;
            par_idx_reg   <= par_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
        word_reg <= word_next;
    end

    // Output stream.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_W - IDX_W){1'b0}}, out_reg.index, out_reg.word};
    assign m_tuser  = {out_reg.err, out_reg.ptype};
    assign m_tlast  = out_reg.last;

    // A parity beat never carries the frame error flag.
    a_parity_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("parity beat with frame error set");

    // The last beat of any packet sits at the final word position.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[WORD_W +: IDX_W] == LAST_POS)
        else $error("packet end at wrong word index");

    // The frame position never runs past the payload length.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("frame position out of range");

    // A memory write always follows the read of the same entry.
    a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> $past(ram_re) && $past(state_reg == ST_IDLE))
        else $error("parity write without preceding read");

endmodule

### tb/tb_xor_parity_fec_encoder.sv
module tb_xor_parity_fec_encoder;

    import xpf_pkg::*;

    localparam int TOTAL_WORDS = 230;
    localparam int QUIET_AFTER = 190;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 120;

    // Mirror of the encoder: tracks frame position, group count and the
    // running parity, and keeps the output beats still owed by the block.
    class parity_encoder_mirror;
        beat_t       pending_beats[$];
        logic [31:0] parity_acc[PAYLOAD_WORDS_DEF];
        logic [31:0] group_seq;
        logic [3:0]  frames_done;
        logic [5:0]  position;
        int          mismatches;

        function new();
            foreach (parity_acc[i])
            begin
                parity_acc[i] = '0;
            end
            group_seq   = '0;
            frames_done = '0;
            position    = '0;
            mismatches  = 0;
        endfunction

        // Account for one word accepted on the input side.
        function void take_word(logic [31:0] w, logic start);
            beat_t b;
            b.ptype = PKT_DATA;
            b.word  = w;
            b.index = '0;
            b.last  = 1'b0;
            b.err   = 1'b0;
            if (start)
            begin
                // An early start abandons the partial frame and the group.
                if (position != 0)
                begin
                    b.err = 1'b1;
                    frames_done = '0;
                end
                if (frames_done == 0)
                begin
                    group_seq = w;
                    foreach (parity_acc[i])
                    begin
                        parity_acc[i] = '0;
                    end
                end
                pending_beats.push_back(b);
                position = 6'd1;
            end
            else if (position != 0)
            begin
                parity_acc[position - 1] ^= w;
                b.index = position;
                b.last  = (position == PAYLOAD_WORDS_DEF);
                pending_beats.push_back(b);
                if (position == PAYLOAD_WORDS_DEF)
                begin
                    position = '0;
                    frames_done = frames_done + 4'd1;
                    // Group complete: sequence beat, then the parity words.
                    if (frames_done == GROUP_FRAMES_DEF)
                    begin
                        b.ptype = PKT_PARITY;
                        b.word  = group_seq;
                        b.index = '0;
                        b.last  = 1'b0;
                        pending_beats.push_back(b);
                        for (int i = 0; i < PAYLOAD_WORDS_DEF; i++)
                        begin
                            b.word  = parity_acc[i];
                            b.index = IDX_W'(i + 1);
                            b.last  = (i + 1 == PAYLOAD_WORDS_DEF);
                            pending_beats.push_back(b);
                        end
                        frames_done = '0;
                    end
                end
                else
                begin
                    position = position + 6'd1;
                end
            end
            // A payload word outside a frame is dropped silently.
        endfunction

        // Compare one delivered beat with the oldest one owed.
        function void match_beat(beat_t got);
            beat_t want;
            if (pending_beats.size() == 0)
            begin
                $error("unexpected output beat: word %08h index %0d", got.word, got.index);
                mismatches++;
                return;
            end
            want = pending_beats.pop_front();
            if (got.ptype !== want.ptype)
            begin
                $error("packet_type: expected %0d, actual %0d", want.ptype, got.ptype);
                mismatches++;
            end
            if (got.word !== want.word)
            begin
                $error("out_word: expected %08h, actual %08h", want.word, got.word);
                mismatches++;
            end
            if (got.index !== want.index)
            begin
                $error("word_index: expected %0d, actual %0d", want.index, got.index);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("packet_last: expected %0d, actual %0d", want.last, got.last);
                mismatches++;
            end
            if (got.err !== want.err)
            begin
                $error("frame_error: expected %0d, actual %0d", want.err, got.err);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    parity_encoder_mirror mirror = new();
    beat_t seen;
    int    words_sent = 0;
    int    cycles = 0;
    int    rx_stall_left = 0;
    bit    tx_idle_on = 1'b1;
    bit    rx_idle_on = 1'b1;
    bit    quiet = 1'b0;

    xor_parity_fec_encoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Both handshakes are observed in one place so that an input beat is
    // always accounted for before an output beat of the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                mirror.take_word(s_tdata, s_tuser[0]);
            end
            if (m_tvalid && m_tready)
            begin
                seen.ptype = m_tuser[0];
                seen.word  = m_tdata[31:0];
                seen.index = m_tdata[37:32];
                seen.last  = m_tlast;
                seen.err   = m_tuser[1];
                mirror.match_beat(seen);
            end
        end
    end

    // Receiver back-pressure in bursts of random length.
    always @(negedge clk)
    begin
        if (quiet || !rx_idle_on)
        begin
            m_tready <= 1'b1;
        end
        else if (rx_stall_left > 0)
        begin
            m_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            rx_stall_left <= $urandom_range(1, 5) - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Present one word and hold it until accepted; returns at a falling edge.
    task automatic send_word(input logic [31:0] w, input logic start, input bit counted);
        int gap;
        if (tx_idle_on && !quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= w;
        s_tuser[0] <= start;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (counted)
        begin
            words_sent++;
        end
        if (words_sent >= QUIET_AFTER)
        begin
            quiet = 1'b1;
        end
        @(negedge clk);
    endtask

    // Hold the input back until the block has delivered everything owed.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (mirror.pending_beats.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // A sequence word followed by a number of random payload words.
    task automatic send_frame(input int payload_count);
        send_word($urandom, 1'b1, 1'b1);
        for (int k = 0; k < payload_count; k++)
        begin
            send_word($urandom, 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        int pick;
        int strays;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Stray payload words with no frame open, at both extremes.
        send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(32'h0000_0000, 1'b0, 1'b1);
        // A partial frame with extreme payload values.
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_word(32'h0000_0000, 1'b0, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(32'hA5A5_A5A5, 1'b0, 1'b1);
        // Early frame starts, including one right after a sequence word.
        send_word(32'h0000_0000, 1'b1, 1'b1);
        send_word(32'h8000_0000, 1'b0, 1'b1);
        send_word(32'h0000_0001, 1'b0, 1'b1);
        send_word(32'h1234_5678, 1'b1, 1'b1);
        send_word(32'h0000_0000, 1'b1, 1'b1);
        send_word(32'h5A5A_5A5A, 1'b0, 1'b1);
        drain_outputs();

        // Mostly complete frames, with truncated frames and stray words mixed in.
        while (words_sent < TOTAL_WORDS)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                send_frame(PAYLOAD_WORDS_DEF);
            end
            else if (pick < 9)
            begin
                send_frame($urandom_range(0, PAYLOAD_WORDS_DEF - 1));
            end
            else
            begin
                strays = $urandom_range(1, 3);
                for (int k = 0; k < strays; k++)
                begin
                    send_word($urandom, 1'b0, 1'b0);
                end
            end
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                drain_outputs();
            end
        end

        drain_outputs();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mirror.mismatches == 0 && mirror.pending_beats.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
